>>> src/gbrf_pkg.sv
// Package: shared constants, codes and types for the GPIO bank register file.
package gbrf_pkg;

  localparam int unsigned NUM_PAIRS_DEF = 5;

  localparam logic [31:0] BANK_BASE    = 32'h01E2_6000;
  localparam logic [31:0] WINDOW_START = 32'h0000_0010;
  localparam int unsigned PAIR_STRIDE  = 40;

  localparam int unsigned OFFS_DIR = 0;
  localparam int unsigned OFFS_OUT = 4;
  localparam int unsigned OFFS_SET = 8;
  localparam int unsigned OFFS_CLR = 12;
  localparam int unsigned OFFS_IN  = 16;

  localparam int unsigned CMD_PAIR     = 2;
  localparam int unsigned CMD_PIN0_BIT = 5;
  localparam int unsigned CMD_PIN1_BIT = 2;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_CMD   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_DIR,
    REG_OUT,
    REG_SET,
    REG_CLR,
    REG_IN,
    REG_OTHER
  } reg_sel_t;

  typedef struct packed {
    logic     hit;
    reg_sel_t sel;
  } dec_t;

endpackage

>>> src/gpio_bank_register_file_top.sv
// Top level: GPIO bank register file with input and result word registers.
//
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word: the input word is registered, then decoded and
// applied to the pair registers as it enters the output register, where its
// result sits until taken. A stalled output holds at most one word in the
// input register before in_ready drops. Reads and writes that fall outside
// the pair window, command pin updates and kind three return read_data 0 with
// hit 0. Direction resets to all ones (every pin an input), outputs to zero.
module gpio_bank_register_file_top
  import gbrf_pkg::*;
#(
  parameter int unsigned NUM_PAIRS = NUM_PAIRS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [1:0]  in_command_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_hit
);

  localparam int unsigned PAIR_W = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;

  logic              s1_v_r;
  logic [1:0]        s1_kind_r;
  logic [31:0]       s1_addr_r;
  logic [31:0]       s1_data_r;
  logic [1:0]        s1_cmd_r;
  logic              adv;
  logic              out_valid_r;
  logic [31:0]       out_read_data_r;
  logic              out_hit_r;
  dec_t              dec;
  logic [PAIR_W-1:0] pair;
  logic [31:0]       rd_data;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_addr_r <= in_address;
      s1_data_r <= in_write_data;
      s1_cmd_r  <= in_command_bits;
    end
  end

  gbrf_decode #(
    .NUM_PAIRS(NUM_PAIRS),
    .PAIR_W   (PAIR_W)
  ) u_decode (
    .kind   (s1_kind_r),
    .address(s1_addr_r),
    .dec    (dec),
    .pair   (pair)
  );

  gbrf_regs #(
    .NUM_PAIRS(NUM_PAIRS),
    .PAIR_W   (PAIR_W)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_v_r && adv),
    .kind    (s1_kind_r),
    .dec     (dec),
    .pair    (pair),
    .wdata   (s1_data_r),
    .cmd_bits(s1_cmd_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && adv) begin
      out_read_data_r <= rd_data;
      out_hit_r       <= dec.hit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_hit       = out_hit_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_read_data_r == '0)
    else $error("miss with non-zero read data");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_addr_r) && $stable(s1_kind_r))
    else $error("input word lost while output stalled");

endmodule

>>> src/gbrf_decode.sv
// Address decoder: window check, pair index and register select.
module gbrf_decode
  import gbrf_pkg::*;
#(
  parameter int unsigned NUM_PAIRS = NUM_PAIRS_DEF,
  parameter int unsigned PAIR_W    = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1
) (
  input  logic [1:0]        kind,
  input  logic [31:0]       address,
  output dec_t              dec,
  output logic [PAIR_W-1:0] pair
);

  localparam int unsigned SPAN  = NUM_PAIRS * PAIR_STRIDE;
  localparam int unsigned REL_W = $clog2(SPAN);
  localparam logic [31:0] LO    = BANK_BASE + WINDOW_START;

  logic [31:0]      rel;
  logic             in_win;
  logic [REL_W-1:0] offs;

  assign rel    = address - LO;
  assign in_win = (address >= LO) && (rel < 32'(SPAN));

  always_comb begin
    pair = '0;
    offs = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      if ((rel[REL_W-1:0] >= REL_W'(p * PAIR_STRIDE)) &&
          (rel[REL_W-1:0] <  REL_W'((p + 1) * PAIR_STRIDE))) begin
        pair = PAIR_W'(p);
        offs = rel[REL_W-1:0] - REL_W'(p * PAIR_STRIDE);
      end
    end
  end

  always_comb begin
    dec.hit = in_win && ((kind == KIND_READ) || (kind == KIND_WRITE));
    if (offs == REL_W'(OFFS_DIR))      dec.sel = REG_DIR;
    else if (offs == REL_W'(OFFS_OUT)) dec.sel = REG_OUT;
    else if (offs == REL_W'(OFFS_SET)) dec.sel = REG_SET;
    else if (offs == REL_W'(OFFS_CLR)) dec.sel = REG_CLR;
    else if (offs == REL_W'(OFFS_IN))  dec.sel = REG_IN;
    else                               dec.sel = REG_OTHER;
  end

endmodule

>>> src/gbrf_regs.sv
// Register store: direction, output and command pin levels, with read mux.
module gbrf_regs
  import gbrf_pkg::*;
#(
  parameter int unsigned NUM_PAIRS = NUM_PAIRS_DEF,
  parameter int unsigned PAIR_W    = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [1:0]        kind,
  input  dec_t              dec,
  input  logic [PAIR_W-1:0] pair,
  input  logic [31:0]       wdata,
  input  logic [1:0]        cmd_bits,
  output logic [31:0]       rd_data
);

  logic [31:0] dir_r [NUM_PAIRS];
  logic [31:0] out_r [NUM_PAIRS];
  logic [31:0] ext_word;
  logic        wr_en;

  assign wr_en = en && dec.hit && (kind == KIND_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        dir_r[p] <= ALL_ONES;
        out_r[p] <= '0;
      end
    end else if (wr_en) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        if (pair == PAIR_W'(p)) begin
          case (dec.sel)
            REG_DIR: dir_r[p] <= wdata;
            REG_OUT: out_r[p] <= wdata;
            REG_SET: out_r[p] <= out_r[p] | wdata;
            REG_CLR: out_r[p] <= out_r[p] & ~wdata;
            default: ;
          endcase
        end
      end
    end
  end

  // only pins 5 and 2 of the command pair ever leave zero
  generate
    if (NUM_PAIRS > CMD_PAIR) begin : g_cmd
      logic [1:0] cmd_lvl_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cmd_lvl_r <= '0;
        end else if (en && (kind == KIND_CMD)) begin
          cmd_lvl_r <= cmd_bits;
        end
      end

      always_comb begin
        ext_word = '0;
        if (pair == PAIR_W'(CMD_PAIR)) begin
          ext_word[CMD_PIN0_BIT] = cmd_lvl_r[0];
          ext_word[CMD_PIN1_BIT] = cmd_lvl_r[1];
        end
      end

      a_cmd_load: assert property (@(posedge clk) disable iff (!rst_n)
        en && (kind == KIND_CMD) |=> cmd_lvl_r == $past(cmd_bits))
        else $error("command pin levels not loaded");
    end else begin : g_no_cmd
      assign ext_word = '0;
    end
  endgenerate

  always_comb begin
    rd_data = '0;
    if (dec.hit && (kind == KIND_READ)) begin
      unique case (dec.sel)
        REG_DIR: rd_data = dir_r[pair];
        REG_OUT: rd_data = out_r[pair];
        REG_IN:  rd_data = (ext_word & dir_r[pair]) | (out_r[pair] & ~dir_r[pair]);
        default: rd_data = '0;
      endcase
    end
  end

  a_dir_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && (dec.sel == REG_DIR) |=> dir_r[$past(pair)] == $past(wdata))
    else $error("direction write lost");

endmodule

>>> test/testbench.sv
// Testbench for gpio_bank_register_file_top: directed table, random accesses, scoreboard.
`timescale 1ns / 100ps

module testbench
  import gbrf_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned WINDOW_BYTES = NUM_PAIRS_DEF * PAIR_STRIDE;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [1:0]  cmd;
    logic        fixed;
    logic [31:0] rd;
    logic        hit;
  } bus_word_t;

  typedef struct packed {
    logic [31:0] rd;
    logic        hit;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [31:0] in_address;
  logic [31:0] in_write_data;
  logic [1:0]  in_command_bits;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;
  logic        out_hit;

  logic [31:0] dir_bits  [NUM_PAIRS_DEF];
  logic [31:0] out_bits  [NUM_PAIRS_DEF];
  logic [31:0] pin_levels[NUM_PAIRS_DEF];

  bus_word_t directed_words[$];
  result_t   awaited_results[$];
  int        mismatches  = 0;
  int        cycle_count = 0;

  gpio_bank_register_file_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_address      (in_address),
    .in_write_data   (in_write_data),
    .in_command_bits (in_command_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_hit         (out_hit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, awaited_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] gpio_addr(input int unsigned pair, input int unsigned offs);
    return BANK_BASE + WINDOW_START + pair * PAIR_STRIDE + offs;
  endfunction

  function automatic int sender_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // register file behaviour: returns the result word and updates the pair state
  task automatic gpio_access(input bus_word_t w, output result_t r);
    logic [32:0]  rel;
    logic         in_win;
    int unsigned  pair;
    int unsigned  offs;
    logic [31:0]  pins;
    r      = '0;
    rel    = {1'b0, w.addr} - {1'b0, BANK_BASE + WINDOW_START};
    in_win = !rel[32] && (rel < WINDOW_BYTES);
    pair   = in_win ? 32'(rel / PAIR_STRIDE) : 0;
    offs   = in_win ? 32'(rel % PAIR_STRIDE) : 0;
    case (w.kind)
      KIND_READ: begin
        if (in_win) begin
          r.hit = 1'b1;
          if (offs == OFFS_DIR) r.rd = dir_bits[pair];
          else if (offs == OFFS_OUT) r.rd = out_bits[pair];
          else if (offs == OFFS_IN)
            r.rd = (pin_levels[pair] & dir_bits[pair]) | (out_bits[pair] & ~dir_bits[pair]);
        end
      end
      KIND_WRITE: begin
        if (in_win) begin
          r.hit = 1'b1;
          if (offs == OFFS_DIR) dir_bits[pair] = w.wdata;
          else if (offs == OFFS_OUT) out_bits[pair] = w.wdata;
          else if (offs == OFFS_SET) out_bits[pair] = out_bits[pair] | w.wdata;
          else if (offs == OFFS_CLR) out_bits[pair] = out_bits[pair] & ~w.wdata;
        end
      end
      KIND_CMD: begin
        if (CMD_PAIR < NUM_PAIRS_DEF) begin
          pins               = pin_levels[CMD_PAIR];
          pins[CMD_PIN0_BIT] = w.cmd[0];
          pins[CMD_PIN1_BIT] = w.cmd[1];
          pin_levels[CMD_PAIR] = pins;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_word(input kind_t k, input logic [31:0] a, input logic [31:0] d,
                          input logic [1:0] c, input logic fixed, input logic [31:0] rd,
                          input logic hit);
    bus_word_t w;
    w.kind  = k;
    w.addr  = a;
    w.wdata = d;
    w.cmd   = c;
    w.fixed = fixed;
    w.rd    = rd;
    w.hit   = hit;
    directed_words.push_back(w);
  endtask

  task automatic send_word(input bus_word_t w, input int gap);
    result_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= w.kind;
    in_address      <= w.addr;
    in_write_data   <= w.wdata;
    in_command_bits <= w.cmd;
    do @(posedge clk); while (!in_ready);
    gpio_access(w, r);
    if (w.fixed) begin
      r.rd  = w.rd;
      r.hit = w.hit;
    end
    awaited_results.push_back(r);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected word, read_data %h hit %b", $time, out_read_data, out_hit);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_read_data !== want.rd) begin
          $display("%0t: read_data expected %h actual %h", $time, want.rd, out_read_data);
          mismatches++;
        end
        if (out_hit !== want.hit) begin
          $display("%0t: hit expected %b actual %b", $time, want.hit, out_hit);
          mismatches++;
        end
      end
    end
  end

  initial begin : result_sink
    int mode;
    int span;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    repeat (400) begin
      out_ready <= ($urandom_range(3) != 0);
      @(posedge clk);
    end
    // long hold-off so the block backs up and drops in_ready
    out_ready <= 1'b0;
    repeat (120) @(posedge clk);
    forever begin
      mode = $urandom_range(9);
      span = $urandom_range(200, 20);
      if (mode == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(90, 30)) @(posedge clk);
      end else if (mode <= 3) begin
        out_ready <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        repeat (span) begin
          out_ready <= ($urandom_range(3) != 0);
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    bus_word_t   w;
    int unsigned pick;
    int unsigned offs;
    int          gap;
    logic [31:0] win;
    win = BANK_BASE + WINDOW_START;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= KIND_READ;
    in_address      <= '0;
    in_write_data   <= '0;
    in_command_bits <= '0;
    for (int p = 0; p < NUM_PAIRS_DEF; p++) begin
      dir_bits[p]   = ALL_ONES;
      out_bits[p]   = '0;
      pin_levels[p] = '0;
    end

    add_word(KIND_READ,  gpio_addr(0, OFFS_DIR), '0, 2'd0, 1'b1, ALL_ONES, 1'b1);
    add_word(KIND_READ,  gpio_addr(0, OFFS_OUT), '0, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_READ,  gpio_addr(4, OFFS_IN), '0, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_READ,  32'h0000_0000, '0, 2'd0, 1'b1, '0, 1'b0);
    add_word(KIND_READ,  ALL_ONES, ALL_ONES, 2'd3, 1'b1, '0, 1'b0);
    add_word(KIND_READ,  win - 1, '0, 2'd0, 1'b1, '0, 1'b0);
    add_word(KIND_READ,  win + WINDOW_BYTES, '0, 2'd0, 1'b1, '0, 1'b0);
    add_word(KIND_READ,  win + WINDOW_BYTES - 1, '0, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_WRITE, gpio_addr(2, OFFS_DIR), '0, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_WRITE, gpio_addr(2, OFFS_OUT), ALL_ONES, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_READ,  gpio_addr(2, OFFS_IN), '0, 2'd0, 1'b0, '0, 1'b0);
    add_word(KIND_WRITE, gpio_addr(2, OFFS_CLR), 32'h0000_FFFF, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_WRITE, gpio_addr(2, OFFS_SET), 32'h0000_0005, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_READ,  gpio_addr(2, OFFS_OUT), '0, 2'd0, 1'b0, '0, 1'b0);
    add_word(KIND_WRITE, gpio_addr(2, OFFS_DIR), ALL_ONES, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_CMD,   32'h0000_0000, '0, 2'd3, 1'b1, '0, 1'b0);
    add_word(KIND_READ,  gpio_addr(2, OFFS_IN), '0, 2'd0, 1'b0, '0, 1'b0);
    add_word(KIND_CMD,   gpio_addr(2, OFFS_IN), ALL_ONES, 2'd1, 1'b1, '0, 1'b0);
    add_word(KIND_READ,  gpio_addr(2, OFFS_IN), '0, 2'd0, 1'b0, '0, 1'b0);
    add_word(KIND_NONE,  gpio_addr(0, OFFS_DIR), '0, 2'd2, 1'b1, '0, 1'b0);
    add_word(KIND_READ,  gpio_addr(0, OFFS_DIR), '0, 2'd0, 1'b0, '0, 1'b0);
    add_word(KIND_WRITE, gpio_addr(1, OFFS_IN), ALL_ONES, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_WRITE, gpio_addr(1, 5), ALL_ONES, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_READ,  gpio_addr(1, OFFS_SET), '0, 2'd0, 1'b1, '0, 1'b1);
    add_word(KIND_WRITE, win + WINDOW_BYTES, ALL_ONES, 2'd0, 1'b1, '0, 1'b0);
    add_word(KIND_READ,  gpio_addr(1, OFFS_OUT), '0, 2'd0, 1'b0, '0, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[k]) send_word(directed_words[k], sender_gap());

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) w.kind = KIND_READ;
      else if (pick < 85) w.kind = KIND_WRITE;
      else if (pick < 97) w.kind = KIND_CMD;
      else w.kind = KIND_NONE;

      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(4))
          0:       offs = OFFS_DIR;
          1:       offs = OFFS_OUT;
          2:       offs = OFFS_SET;
          3:       offs = OFFS_CLR;
          default: offs = OFFS_IN;
        endcase
        w.addr = gpio_addr($urandom_range(NUM_PAIRS_DEF - 1), offs);
      end else if (pick < 85) begin
        w.addr = win + $urandom_range(WINDOW_BYTES - 1);
      end else if (pick < 93) begin
        w.addr = ($urandom_range(1) ? win : win + WINDOW_BYTES) - 4 + $urandom_range(7);
      end else begin
        w.addr = $urandom();
      end

      pick = $urandom_range(99);
      if (pick < 10) w.wdata = '0;
      else if (pick < 20) w.wdata = ALL_ONES;
      else w.wdata = $urandom();
      w.cmd   = 2'($urandom_range(3));
      w.fixed = 1'b0;
      w.rd    = '0;
      w.hit   = 1'b0;

      if (i == RANDOM_WORDS / 2) begin
        // drain everything before carrying on
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
      end
      gap = ((i / 100) % 3 == 1) ? 0 : sender_gap();
      send_word(w, gap);
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> gpio_bank_register_file_top.f
src/gbrf_pkg.sv
src/gbrf_decode.sv
src/gbrf_regs.sv
src/gpio_bank_register_file_top.sv
test/testbench.sv
